// File: src/cstl_pkg.sv
package cstl_pkg;

    // operation codes on s_opcode
    localparam logic [2:0] OP_CONNECT    = 3'd0;
    localparam logic [2:0] OP_DISCONNECT = 3'd1;
    localparam logic [2:0] OP_CLAIM      = 3'd2;
    localparam logic [2:0] OP_RELEASE    = 3'd3;
    localparam logic [2:0] OP_WAKEUP     = 3'd4;
    localparam logic [2:0] OP_LISTEN     = 3'd5;
    localparam logic [2:0] OP_SLEEP      = 3'd6;

    // lock modes
    localparam logic [1:0] MODE_INIT   = 2'd0;
    localparam logic [1:0] MODE_WAKEUP = 2'd1;
    localparam logic [1:0] MODE_IDLE   = 2'd2;
    localparam logic [1:0] MODE_BUSY   = 2'd3;

    localparam int ID_W   = 32;
    localparam int SLOT_W = 3;

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONN = 4'b0010,
        ST_DISC = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    // one result beat
    typedef struct packed {
        logic              status;
        logic [SLOT_W-1:0] slot_index;
        logic [1:0]        lock_mode;
        logic [ID_W-1:0]   lock_owner;
    } result_t;

endpackage

// File: src/cstl_slot_ram.sv
// Client id store: one write port, one read port, registered read data.
module cstl_slot_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [cstl_pkg::ID_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [cstl_pkg::ID_W-1:0] rdata
);

    logic [cstl_pkg::ID_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/client_slot_table_with_lock_core.sv
// Channel  Ports                                          Direction
// s_       s_valid s_ready s_opcode s_client_id s_listen_ok  in
// m_       m_valid m_ready m_status m_slot_index m_lock_mode m_lock_owner  out
//
// Claim, release, wakeup, listen, sleep and the unused code finish in the
// accept cycle. Connect scans one free mark per cycle, from slot 0 up to the
// lowest free slot, and fails at the last slot when the table is full.
// Disconnect reads the id store through its single read port, one slot a
// cycle, and finishes after comparing the last slot. One operation at a time.
// Reset marks every slot free and every stored id as never written, so it reads zero.
// A beat finishing behind a full output register is parked, s_ready low.
module client_slot_table_with_lock_core #(
    parameter int MAX_CLIENTS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [2:0]                  s_opcode,
    input  logic [cstl_pkg::ID_W-1:0]   s_client_id,
    input  logic                        s_listen_ok,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_status,
    output logic [cstl_pkg::SLOT_W-1:0] m_slot_index,
    output logic [1:0]                  m_lock_mode,
    output logic [cstl_pkg::ID_W-1:0]   m_lock_owner
);

    localparam int IDXW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(MAX_CLIENTS - 1);

    cstl_pkg::state_t  state_reg, state_next;
    cstl_pkg::result_t out_reg, out_next;
    cstl_pkg::result_t res_reg, res_next;
    cstl_pkg::result_t fin_res;
    logic              m_valid_reg, m_valid_next;
    logic              fin;
    logic              out_free;

    logic [1:0]                mode_reg, mode_next;
    logic [cstl_pkg::ID_W-1:0] owner_reg, owner_next;
    logic [cstl_pkg::ID_W-1:0] id_reg, id_next;
    logic [MAX_CLIENTS-1:0]    free_reg, free_next;
    logic [MAX_CLIENTS-1:0]    written_reg, written_next;

    logic [IDXW-1:0] idx_reg, idx_next;
    logic            rd_on_reg, rd_on_next;
    logic            cmp_on_reg, cmp_on_next;
    logic [IDXW-1:0] cmp_idx_reg, cmp_idx_next;
    logic            hit_reg, hit_next;
    logic            wr_q_reg;

    logic                      mem_we;
    logic [cstl_pkg::ID_W-1:0] rd_data;
    logic [cstl_pkg::ID_W-1:0] stored_id;
    logic                      match;
    logic                      hit_all;

    cstl_slot_ram #(
        .DEPTH (MAX_CLIENTS),
        .AW    (IDXW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (idx_reg),
        .wdata (id_reg),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    // written mark follows the read data so a never-written slot reads zero
    always_ff @(posedge aclk) begin
        wr_q_reg <= written_reg[idx_reg];
    end

    assign stored_id = wr_q_reg ? rd_data : '0;
    assign match     = (stored_id == id_reg);
    assign hit_all   = hit_reg | match;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == cstl_pkg::ST_IDLE);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        out_next     = out_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        mode_next    = mode_reg;
        owner_next   = owner_reg;
        id_next      = id_reg;
        free_next    = free_reg;
        written_next = written_reg;
        idx_next     = idx_reg;
        rd_on_next   = rd_on_reg;
        cmp_on_next  = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        hit_next     = hit_reg;
        mem_we       = 1'b0;
        fin          = 1'b0;
        fin_res      = '0;

        case (state_reg)
            cstl_pkg::ST_IDLE: begin
                if (s_valid) begin
                    id_next  = s_client_id;
                    idx_next = '0;
                    case (s_opcode)
                        cstl_pkg::OP_CONNECT: begin
                            state_next = cstl_pkg::ST_CONN;
                        end
                        cstl_pkg::OP_DISCONNECT: begin
                            rd_on_next = 1'b1;
                            hit_next   = 1'b0;
                            state_next = cstl_pkg::ST_DISC;
                        end
                        cstl_pkg::OP_CLAIM: begin
                            fin = 1'b1;
                            if (mode_reg == cstl_pkg::MODE_IDLE || owner_reg == s_client_id) begin
                                mode_next  = cstl_pkg::MODE_BUSY;
                                owner_next = s_client_id;
                            end else begin
                                fin_res.status = 1'b1;
                            end
                        end
                        cstl_pkg::OP_RELEASE: begin
                            fin       = 1'b1;
                            mode_next = cstl_pkg::MODE_IDLE;
                        end
                        cstl_pkg::OP_WAKEUP: begin
                            fin       = 1'b1;
                            mode_next = cstl_pkg::MODE_WAKEUP;
                        end
                        cstl_pkg::OP_LISTEN: begin
                            fin = 1'b1;
                            if (mode_reg == cstl_pkg::MODE_WAKEUP && s_listen_ok) begin
                                mode_next = cstl_pkg::MODE_IDLE;
                            end
                        end
                        cstl_pkg::OP_SLEEP: begin
                            fin       = 1'b1;
                            mode_next = cstl_pkg::MODE_INIT;
                            free_next = '1;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            // lowest free slot, one mark a cycle
            cstl_pkg::ST_CONN: begin
                if (free_reg[idx_reg]) begin
                    mem_we                = 1'b1;
                    free_next[idx_reg]    = 1'b0;
                    written_next[idx_reg] = 1'b1;
                    fin                   = 1'b1;
                    fin_res.slot_index    = cstl_pkg::SLOT_W'(idx_reg);
                end else if (idx_reg == LAST_IDX) begin
                    fin            = 1'b1;
                    fin_res.status = 1'b1;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            // read one slot a cycle, compare it in the next cycle
            cstl_pkg::ST_DISC: begin
                if (rd_on_reg) begin
                    cmp_on_next  = 1'b1;
                    cmp_idx_next = idx_reg;
                    if (idx_reg == LAST_IDX) begin
                        rd_on_next = 1'b0;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                if (cmp_on_reg) begin
                    if (match) begin
                        free_next[cmp_idx_reg] = 1'b1;
                        hit_next               = 1'b1;
                    end
                    if (cmp_idx_reg == LAST_IDX) begin
                        fin = 1'b1;
                        if (hit_all && mode_reg == cstl_pkg::MODE_BUSY && owner_reg == id_reg) begin
                            mode_next = cstl_pkg::MODE_IDLE;
                        end
                    end
                end
            end
            cstl_pkg::ST_DONE: begin
                if (out_free) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = cstl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cstl_pkg::ST_IDLE;
            end
        endcase

        // hand the result to the output register, or park it
        if (fin) begin
            fin_res.lock_mode  = mode_next;
            fin_res.lock_owner = owner_next;
            if (out_free) begin
                out_next     = fin_res;
                m_valid_next = 1'b1;
                state_next   = cstl_pkg::ST_IDLE;
            end else begin
                res_next   = fin_res;
                state_next = cstl_pkg::ST_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cstl_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            mode_reg    <= cstl_pkg::MODE_INIT;
            owner_reg   <= '0;
            free_reg    <= '1;
            written_reg <= '0;
            rd_on_reg   <= 1'b0;
            cmp_on_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            mode_reg    <= mode_next;
            owner_reg   <= owner_next;
            free_reg    <= free_next;
            written_reg <= written_next;
            rd_on_reg   <= rd_on_next;
            cmp_on_reg  <= cmp_on_next;
        end
        out_reg     <= out_next;
        res_reg     <= res_next;
        id_reg      <= id_next;
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        hit_reg     <= hit_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = out_reg.status;
    assign m_slot_index = out_reg.slot_index;
    assign m_lock_mode  = out_reg.lock_mode;
    assign m_lock_owner = out_reg.lock_owner;

    // a parked result only exists while the output register is occupied
    a_done_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cstl_pkg::ST_DONE) |-> m_valid_reg)
        else $error("parked result with empty output register");

    // a slot taken by connect is no longer free
    a_conn_takes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cstl_pkg::ST_CONN && free_reg[idx_reg]) |=> !free_reg[$past(idx_reg)])
        else $error("connect left its slot free");

    // sleep frees the whole table
    a_sleep_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_opcode == cstl_pkg::OP_SLEEP) |=> (&free_reg))
        else $error("sleep did not free every slot");

endmodule
